// ----- design/thc_pkg.sv -----
// Shared types, constants and helper functions for the temperature and humidity
// compensation pipeline. No dependencies; imported by the top level and its checker.

package thc_pkg;

    // Pipeline depth: one register stage per step of the compensation arithmetic.
    localparam int NUM_STAGES = 16;

    // Configuration port geometry: eight 32-bit registers at byte offsets 0..28.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Stream payload widths, padded to whole bytes.
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 32;

    // Reset values of the calibration registers.
    localparam logic [15:0] TEMP_CAL_ONE_RST  = 16'd26487;
    localparam logic [15:0] TEMP_CAL_TWO_RST  = 16'd26223;
    localparam logic [15:0] HUM_CAL_ONE_RST   = 16'd10211;
    localparam logic [15:0] HUM_CAL_TWO_RST   = 16'd16611;
    localparam logic [7:0]  HUM_CAL_FOUR_RST  = 8'd45;
    localparam logic [7:0]  HUM_CAL_FIVE_RST  = 8'd20;
    localparam logic [7:0]  HUM_CAL_SIX_RST   = 8'd120;
    localparam logic [7:0]  HUM_CAL_SEVEN_RST = 8'h9C;

    // Fixed constants of the compensation formulas.
    localparam logic [25:0]        TEMP_QUAD_MUL = 26'd48;     // quadratic coefficient 3, times 16
    localparam logic signed [19:0] HUM_UNITY     = 20'sd16384; // 1.0 in the sensitivity scale
    localparam logic signed [43:0] HUM_FULL_PCT  = 44'sd100;

    // Reciprocal of 100 for 27-bit magnitudes: ceil(2^34 / 100), exact for all inputs below 2^27.
    localparam int          DIV100_SHIFT = 34;
    localparam logic [27:0] DIV100_MAGIC = 28'd171798692;

    // Register map, by word index.
    typedef enum logic [2:0] {
        REG_TEMP_CAL_ONE  = 3'd0,
        REG_TEMP_CAL_TWO  = 3'd1,
        REG_HUM_CAL_ONE   = 3'd2,
        REG_HUM_CAL_TWO   = 3'd3,
        REG_HUM_CAL_FOUR  = 3'd4,
        REG_HUM_CAL_FIVE  = 3'd5,
        REG_HUM_CAL_SIX   = 3'd6,
        REG_HUM_CAL_SEVEN = 3'd7
    } cfg_idx_t;

    // Everything an item carries down the pipeline. Each stage fills in its own fields
    // and passes the rest along unchanged.
    typedef struct packed {
        logic signed [16:0] d;      // temp_raw - t1
        logic signed [20:0] v1;     // hum_raw - 16*h1
        logic signed [32:0] p;      // d * t2
        logic        [31:0] sq;     // d squared
        logic signed [23:0] tfine;
        logic signed [15:0] tc;     // temperature, hundredths of a degree
        logic signed [7:0]  tw;     // temperature, whole degrees
        logic signed [23:0] ph4;
        logic signed [23:0] ph5;
        logic signed [23:0] ph7;
        logic signed [16:0] q4;
        logic signed [16:0] q5;
        logic signed [16:0] q7;
        logic signed [32:0] m;      // tc * q5
        logic signed [13:0] v4;
        logic signed [18:0] t2q;
        logic signed [19:0] hsum;
        logic signed [25:0] v2;
        logic signed [46:0] v3;
        logic        [50:0] v5;
        logic signed [40:0] plo;
        logic signed [39:0] phi;
        logic signed [65:0] prod;
        logic signed [65:0] y;
        logic        [6:0]  hp;     // relative humidity, whole percent
    } pipe_t;

    // Signed division by 100, truncating toward zero, for |x| < 2^26.
    function automatic logic signed [20:0] div100(input logic signed [26:0] x);
        logic [26:0] mag;
        logic [54:0] prod;
        logic [20:0] q;
        begin
            mag  = x[26] ? 27'(-x) : 27'(x);
            prod = 55'(mag) * 55'(DIV100_MAGIC);
            q    = prod[54:DIV100_SHIFT];
            return x[26] ? -$signed(q) : $signed(q);
        end
    endfunction

endpackage

// ----- design/temp_humidity_compensation.sv -----
// Top level of the temperature and humidity compensation block: calibration register
// file, a sixteen-stage arithmetic pipeline and the stream handshakes. Uses thc_pkg.

// Each transfer on the input stream carries one raw temperature and one raw humidity
// reading and produces exactly one transfer on the output stream: the compensated
// temperature in hundredths of a degree (saturated to 16 bits), the same value in whole
// degrees (truncated toward zero and saturated to a signed byte), and the relative
// humidity in whole percent, clamped to 0..100. The block takes one item per clock
// unless a stalled output has filled every stage, and each result passes through all
// stages of the arithmetic pipeline, in which no stage has more than one multiplication
// or one wide addition on its longest path. Each stage advances when it is empty or the
// stage after it moves, so gaps close up while the output is stalled and the input
// keeps being accepted until every stage is full; nothing is dropped or repeated under
// back-pressure. Calibration registers sit on an APB-style port at byte offsets 0x00 to
// 0x1C, are read back as stored, and must only be written while no item is in flight.

module temp_humidity_compensation
    import thc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input stream. tdata, lowest bit up: temp_raw[15:0], hum_raw[15:0].
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,

    // Output stream. tdata, lowest bit up: temp_centi[15:0], temp_whole[7:0],
    // hum_percent[6:0], one zero pad bit.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,

    // Calibration register port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Calibration registers
    // ------------------------------------------------------------------
    logic [15:0] temp_cal_one_reg;
    logic [15:0] temp_cal_two_reg;
    logic [15:0] hum_cal_one_reg;
    logic [15:0] hum_cal_two_reg;
    logic [7:0]  hum_cal_four_reg;
    logic [7:0]  hum_cal_five_reg;
    logic [7:0]  hum_cal_six_reg;
    logic [7:0]  hum_cal_seven_reg;

    logic     cfg_wr;
    cfg_idx_t cfg_idx;

    // The port never inserts wait states, so a write completes in its access cycle.
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = cfg_idx_t'(paddr[CFG_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cal_one_reg  <= TEMP_CAL_ONE_RST;
            temp_cal_two_reg  <= TEMP_CAL_TWO_RST;
            hum_cal_one_reg   <= HUM_CAL_ONE_RST;
            hum_cal_two_reg   <= HUM_CAL_TWO_RST;
            hum_cal_four_reg  <= HUM_CAL_FOUR_RST;
            hum_cal_five_reg  <= HUM_CAL_FIVE_RST;
            hum_cal_six_reg   <= HUM_CAL_SIX_RST;
            hum_cal_seven_reg <= HUM_CAL_SEVEN_RST;
        end
        else if (cfg_wr)
        begin
            // Bits above a register's width are dropped.
            case (cfg_idx)
                REG_TEMP_CAL_ONE:  temp_cal_one_reg  <= pwdata[15:0];
                REG_TEMP_CAL_TWO:  temp_cal_two_reg  <= pwdata[15:0];
                REG_HUM_CAL_ONE:   hum_cal_one_reg   <= pwdata[15:0];
                REG_HUM_CAL_TWO:   hum_cal_two_reg   <= pwdata[15:0];
                REG_HUM_CAL_FOUR:  hum_cal_four_reg  <= pwdata[7:0];
                REG_HUM_CAL_FIVE:  hum_cal_five_reg  <= pwdata[7:0];
                REG_HUM_CAL_SIX:   hum_cal_six_reg   <= pwdata[7:0];
                REG_HUM_CAL_SEVEN: hum_cal_seven_reg <= pwdata[7:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_TEMP_CAL_ONE:  prdata = {16'd0, temp_cal_one_reg};
            REG_TEMP_CAL_TWO:  prdata = {16'd0, temp_cal_two_reg};
            REG_HUM_CAL_ONE:   prdata = {16'd0, hum_cal_one_reg};
            REG_HUM_CAL_TWO:   prdata = {16'd0, hum_cal_two_reg};
            REG_HUM_CAL_FOUR:  prdata = {24'd0, hum_cal_four_reg};
            REG_HUM_CAL_FIVE:  prdata = {24'd0, hum_cal_five_reg};
            REG_HUM_CAL_SIX:   prdata = {24'd0, hum_cal_six_reg};
            REG_HUM_CAL_SEVEN: prdata = {24'd0, hum_cal_seven_reg};
            default:           prdata = '0;
        endcase
    end

    // Signed views of the signed calibration terms.
    logic signed [15:0] t2_cal;
    logic signed [7:0]  h4_cal;
    logic signed [7:0]  h5_cal;
    logic signed [7:0]  h7_cal;

    assign t2_cal = $signed(temp_cal_two_reg);
    assign h4_cal = $signed(hum_cal_four_reg);
    assign h5_cal = $signed(hum_cal_five_reg);
    assign h7_cal = $signed(hum_cal_seven_reg);

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    // A stage loads when it is empty or when the stage after it is moving on. The last
    // stage is the output register, which moves on when the consumer takes the transfer.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign s_tready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Arithmetic pipeline
    // ------------------------------------------------------------------
    pipe_t pipe_reg  [NUM_STAGES];
    pipe_t pipe_next [NUM_STAGES];

    always_comb
    begin
        logic [16:0]        d_abs;
        logic [19:0]        c_scaled;
        logic [25:0]        c_mul;
        logic signed [26:0] t_round;
        logic signed [20:0] tw_div;
        logic signed [17:0] v4_sum;
        logic signed [36:0] h2_prod;
        logic signed [32:0] v3_shr;
        logic [30:0]        s_abs;
        logic [61:0]        s_sq;
        logic signed [43:0] y_pct;

        // By default every stage after the first passes its item on untouched; stage 0 starts from zero.
        pipe_next[0] = '0;
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end

        // Stage 0: offset the raw readings.
        pipe_next[0].d  = $signed({1'b0, s_tdata[15:0]}) - $signed({1'b0, temp_cal_one_reg});
        pipe_next[0].v1 = $signed({5'd0, s_tdata[31:16]})
                        - $signed({1'b0, hum_cal_one_reg, 4'd0});

        // Stage 1: linear product and square of the temperature offset. The linear term
        // of the formula uses twice the offset, which the shift in stage 2 accounts for.
        d_abs           = pipe_reg[0].d[16] ? 17'(-pipe_reg[0].d) : 17'(pipe_reg[0].d);
        pipe_next[1].p  = 33'(pipe_reg[0].d) * 33'(t2_cal);
        pipe_next[1].sq = 32'(d_abs[15:0]) * 32'(d_abs[15:0]);

        // Stage 2: fine temperature, linear plus quadratic term.
        c_scaled           = pipe_reg[1].sq[31:12];
        c_mul              = 26'(c_scaled) * TEMP_QUAD_MUL;
        pipe_next[2].tfine = 24'(pipe_reg[1].p >>> 10) + $signed({12'd0, c_mul[25:14]});

        // Stage 3: scale to hundredths of a degree and saturate.
        t_round = (27'(pipe_reg[2].tfine) * 27'sd5 + 27'sd128) >>> 8;
        if (t_round > 27'sd32767)
        begin
            pipe_next[3].tc = 16'sh7FFF;
        end
        else if (t_round < -27'sd32768)
        begin
            pipe_next[3].tc = 16'sh8000;
        end
        else
        begin
            pipe_next[3].tc = t_round[15:0];
        end

        // Stage 4: whole degrees, and the temperature products of the humidity terms.
        tw_div = div100(27'(pipe_reg[3].tc));
        if (tw_div > 21'sd127)
        begin
            pipe_next[4].tw = 8'sd127;
        end
        else if (tw_div < -21'sd128)
        begin
            pipe_next[4].tw = -8'sd128;
        end
        else
        begin
            pipe_next[4].tw = tw_div[7:0];
        end
        pipe_next[4].ph4 = 24'(pipe_reg[3].tc) * 24'(h4_cal);
        pipe_next[4].ph5 = 24'(pipe_reg[3].tc) * 24'(h5_cal);
        pipe_next[4].ph7 = 24'(pipe_reg[3].tc) * 24'(h7_cal);

        // Stage 5: divide the three products by 100.
        pipe_next[5].q4 = 17'(div100(27'(pipe_reg[4].ph4)));
        pipe_next[5].q5 = 17'(div100(27'(pipe_reg[4].ph5)));
        pipe_next[5].q7 = 17'(div100(27'(pipe_reg[4].ph7)));

        // Stage 6: quadratic temperature product and the quadratic humidity coefficient.
        pipe_next[6].m  = 33'(pipe_reg[5].tc) * 33'(pipe_reg[5].q5);
        v4_sum          = 18'($signed({1'b0, hum_cal_six_reg, 7'd0})) + 18'(pipe_reg[5].q7);
        pipe_next[6].v4 = v4_sum[17:4];

        // Stage 7: scale the quadratic temperature term.
        pipe_next[7].t2q = 19'(div100(27'(pipe_reg[6].m >>> 6)));

        // Stage 8: temperature-dependent sensitivity factor.
        pipe_next[8].hsum = 20'(pipe_reg[7].q4) + 20'(pipe_reg[7].t2q) + HUM_UNITY;

        // Stage 9: apply the sensitivity calibration.
        h2_prod         = 37'($signed({1'b0, hum_cal_two_reg})) * 37'(pipe_reg[8].hsum);
        pipe_next[9].v2 = 26'(h2_prod >>> 10);

        // Stage 10: scaled humidity.
        pipe_next[10].v3 = 47'(pipe_reg[9].v1) * 47'(pipe_reg[9].v2);

        // Stage 11: square of the scaled humidity. Its magnitude stays below 2^31.
        v3_shr           = 33'(pipe_reg[10].v3 >>> 14);
        s_abs            = v3_shr[32] ? 31'(-v3_shr) : 31'(v3_shr);
        s_sq             = 62'(s_abs) * 62'(s_abs);
        pipe_next[11].v5 = s_sq[60:10];

        // Stage 12: quadratic correction, split into two narrower partial products.
        pipe_next[12].plo = 41'(pipe_reg[11].v4) * 41'($signed({1'b0, pipe_reg[11].v5[25:0]}));
        pipe_next[12].phi = 40'(pipe_reg[11].v4) * 40'($signed({1'b0, pipe_reg[11].v5[50:26]}));

        // Stage 13: recombine the partial products.
        pipe_next[13].prod = (66'(pipe_reg[12].phi) <<< 26) + 66'(pipe_reg[12].plo);

        // Stage 14: corrected humidity.
        pipe_next[14].y = 66'(pipe_reg[13].v3) + (pipe_reg[13].prod >>> 1);

        // Stage 15: milli-percent scaling, clamp to 0..100000 and division by 1000
        // collapse into one shift by 22 and a clamp to 0..100.
        y_pct = 44'(pipe_reg[14].y >>> 22);
        if (y_pct[43])
        begin
            pipe_next[15].hp = 7'd0;
        end
        else if (y_pct > HUM_FULL_PCT)
        begin
            pipe_next[15].hp = 7'd100;
        end
        else
        begin
            pipe_next[15].hp = y_pct[6:0];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stream
    // ------------------------------------------------------------------
    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {1'b0,
                       pipe_reg[NUM_STAGES-1].hp,
                       pipe_reg[NUM_STAGES-1].tw,
                       pipe_reg[NUM_STAGES-1].tc};

endmodule

// ----- design/thc_checker.sv -----
// Port-level checker for the temperature and humidity compensation block, with the
// bind statement that attaches it to the top level. Uses thc_pkg.

module thc_checker
    import thc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // Humidity never leaves the clamped range.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[30:24] <= 7'd100))
        else $error("hum_percent above 100");

    // Whole degrees carry the sign of the hundredths value, or are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[23] == m_tdata[15]) || (m_tdata[23:16] == 8'd0)))
        else $error("temp_whole sign disagrees with temp_centi");

    // The pad bit above the humidity field stays clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31] == 1'b0))
        else $error("output pad bit set");

    // A stalled result is held unchanged until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output transfer changed or dropped");

endmodule

bind temp_humidity_compensation thc_checker u_thc_checker (.*);

// ----- tb/tb_temp_humidity_compensation.sv -----
// Self-checking testbench for the temperature and humidity compensation block.
// Depends on thc_pkg and temp_humidity_compensation; it needs no other files.

module tb_temp_humidity_compensation;

    timeunit 1ns;
    timeprecision 1ps;

    import thc_pkg::*;

    // Clock, reset and run length.
    localparam realtime CLK_PERIOD     = 20.0;
    localparam int      RESET_CYCLES   = 7;
    localparam longint  TIMEOUT_CYCLES = 250000;

    // Fixed numbers of the compensation formulas.
    localparam longint QUAD_COEF   = 3;
    localparam longint HUM_ONE     = 1 << 14;
    localparam longint MILLI_FULL  = 100000;
    localparam longint CENTI_MIN   = -32768;
    localparam longint CENTI_MAX   = 32767;
    localparam longint WHOLE_MIN   = -128;
    localparam longint WHOLE_MAX   = 127;

    // Register map geometry and test shaping.
    localparam int NUM_CAL_REGS     = 8;
    localparam int CFG_STRIDE       = 4;
    localparam int HOLD_OFF_CYCLES  = 300;
    localparam int MAX_REPORTED     = 10;
    localparam int ITEMS_PER_PHASE  = 80;
    localparam int BACKLOG_ITEMS    = 60;
    localparam int PAUSE_ITEMS      = 25;

    // One compensated reading, as carried on the output stream.
    typedef struct {
        logic signed [15:0] temp_centi;
        logic signed [7:0]  temp_whole;
        logic        [6:0]  hum_percent;
    } reading_t;

    // One full set of calibration values, in register order; eight-bit registers use
    // the low byte only.
    typedef logic [15:0] cal_set_t [NUM_CAL_REGS];

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // temp_raw[15:0], hum_raw[15:0]

    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // temp_centi[15:0], temp_whole[7:0],
                                           // hum_percent[6:0], pad bit

    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // Our own copy of the calibration registers, as the block should hold them after
    // the bits above each register's width have been dropped.
    logic [15:0] cal_regs [NUM_CAL_REGS] = '{
        TEMP_CAL_ONE_RST, TEMP_CAL_TWO_RST, HUM_CAL_ONE_RST, HUM_CAL_TWO_RST,
        {8'h00, HUM_CAL_FOUR_RST}, {8'h00, HUM_CAL_FIVE_RST},
        {8'h00, HUM_CAL_SIX_RST}, {8'h00, HUM_CAL_SEVEN_RST}
    };

    // Readings predicted for accepted input transfers, oldest first.
    reading_t expected_readings [$];
    int       mismatch_count = 0;

    // Idling knobs, in percent of cycles, set by the test tasks.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // A test asks for a long receiver hold-off by bumping this count; the result
    // monitor notices the change and counts the hold-off down itself.
    int hold_off_requests = 0;

    temp_humidity_compensation i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Predicts the reading that the block must return for one pair of raw values
    // under the current calibration. Every intermediate fits in 64 signed bits, so
    // longint arithmetic is exact here; >>> floors and / truncates toward zero.
    function automatic reading_t compensate_reading(input logic [15:0] temp_raw,
                                                    input logic [15:0] hum_raw);
        longint t1, t2, h1, h2, h4, h5, h6, h7;
        longint dt, half, quad, fine, centi;
        longint offs, sens, prod, curve, sq, corr, milli;
        reading_t r;
        t1 = longint'(cal_regs[REG_TEMP_CAL_ONE]);
        t2 = longint'($signed(cal_regs[REG_TEMP_CAL_TWO]));
        h1 = longint'(cal_regs[REG_HUM_CAL_ONE]);
        h2 = longint'(cal_regs[REG_HUM_CAL_TWO]);
        h4 = longint'($signed(cal_regs[REG_HUM_CAL_FOUR][7:0]));
        h5 = longint'($signed(cal_regs[REG_HUM_CAL_FIVE][7:0]));
        h6 = longint'(cal_regs[REG_HUM_CAL_SIX][7:0]);
        h7 = longint'($signed(cal_regs[REG_HUM_CAL_SEVEN][7:0]));

        // Temperature: linear gain plus a small quadratic term, then hundredths.
        dt    = 2 * (longint'(temp_raw) - t1);
        half  = dt >>> 1;
        quad  = (half * half) >>> 12;
        quad  = (quad * (QUAD_COEF * 16)) >>> 14;
        fine  = ((dt * t2) >>> 11) + quad;
        centi = clamp((fine * 5 + 128) >>> 8, CENTI_MIN, CENTI_MAX);
        r.temp_centi = 16'(centi);
        r.temp_whole = 8'(clamp(centi / 100, WHOLE_MIN, WHOLE_MAX));

        // Humidity works from the saturated temperature.
        offs  = longint'(hum_raw) - h1 * 16;
        sens  = (h2 * ((centi * h4) / 100
                       + ((centi * ((centi * h5) / 100)) >>> 6) / 100
                       + HUM_ONE)) >>> 10;
        prod  = offs * sens;
        curve = (h6 * 128 + (centi * h7) / 100) >>> 4;
        sq    = prod >>> 14;
        sq    = (sq * sq) >>> 10;
        corr  = (curve * sq) >>> 1;
        milli = (((prod + corr) >>> 10) * 1000) >>> 12;
        r.hum_percent = 7'(clamp(milli, 0, MILLI_FULL) / 1000);
        return r;
    endfunction

    function automatic void report_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTED)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // Offers one pair of raw readings, idling first as the current knob says, and
    // returns at the clock edge on which the transfer takes place. It leaves tvalid
    // high so that a following item can go back to back.
    task automatic send_reading(input logic [15:0] temp_raw, input logic [15:0] hum_raw);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {hum_raw, temp_raw};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_readings.push_back(compensate_reading(temp_raw, hum_raw));
    endtask

    // Random readings: half of the temperatures sit close to the calibration offset,
    // where the quadratic term and the sign changes live, and half of the humidities
    // sit close to the humidity offset, so that the clamp is not the usual outcome.
    task automatic send_random_reading();
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        if ($urandom_range(1))
            temp_raw = 16'($urandom);
        else
            temp_raw = cal_regs[REG_TEMP_CAL_ONE] + 16'($urandom_range(8191)) - 16'd4096;
        if ($urandom_range(1))
            hum_raw = 16'($urandom);
        else
            hum_raw = 16'(cal_regs[REG_HUM_CAL_ONE] * 16) + 16'($urandom_range(16383));
        send_reading(temp_raw, hum_raw);
    endtask

    // Drops tvalid and waits until every predicted reading has come back. Each input
    // yields exactly one result, so the pipeline is empty at that point.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_readings.size() != 0)
            @(posedge clk);
    endtask

    // Writes all eight calibration registers, each with a setup phase and an access phase.
    // Bits above a register's width are filled with noise; the block must drop them.
    task automatic load_calibration(input cal_set_t vals);
        logic [CFG_DATA_W-1:0] word;
        for (int i = 0; i < NUM_CAL_REGS; i++)
        begin
            word = $urandom;
            if (i >= int'(REG_HUM_CAL_FOUR))
                word[7:0] = vals[i][7:0];
            else
                word[15:0] = vals[i];
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= CFG_ADDR_W'(i * CFG_STRIDE);
            pwdata  <= word;
            @(posedge clk);
            penable <= 1'b1;
            @(posedge clk);
            while (!pready)
                @(posedge clk);
            cal_regs[i] = (i >= int'(REG_HUM_CAL_FOUR)) ? {8'h00, vals[i][7:0]} : vals[i];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic cal_set_t random_calibration(input bit plausible);
        cal_set_t c;
        c[REG_TEMP_CAL_ONE]  = 16'($urandom);
        c[REG_TEMP_CAL_TWO]  = 16'($urandom);
        // A plausible humidity offset keeps 16*h1 within reach of a 16-bit reading.
        c[REG_HUM_CAL_ONE]   = plausible ? 16'($urandom_range(4095)) : 16'($urandom);
        c[REG_HUM_CAL_TWO]   = 16'($urandom);
        c[REG_HUM_CAL_FOUR]  = 16'($urandom_range(255));
        c[REG_HUM_CAL_FIVE]  = 16'($urandom_range(255));
        c[REG_HUM_CAL_SIX]   = 16'($urandom_range(255));
        c[REG_HUM_CAL_SEVEN] = 16'($urandom_range(255));
        return c;
    endfunction

    // Result monitor and receiver. Every output transfer is checked against the
    // oldest prediction; tready is driven here, from random stalls or a hold-off.
    always @(posedge clk)
    begin : result_monitor
        reading_t want;
        int       hold_off_served;
        int       stall_left;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_failure($sformatf("result %h arrived with none expected", m_tdata));
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (m_tdata[15:0] !== want.temp_centi || m_tdata[23:16] !== want.temp_whole
                        || m_tdata[30:24] !== want.hum_percent)
                        report_failure($sformatf(
                            "temp_centi exp %0d got %0d, temp_whole exp %0d got %0d, %s",
                            want.temp_centi, $signed(m_tdata[15:0]),
                            want.temp_whole, $signed(m_tdata[23:16]),
                            $sformatf("hum_percent exp %0d got %0d",
                                      want.hum_percent, m_tdata[30:24])));
                end
            end
            if (hold_off_requests != hold_off_served)
            begin
                hold_off_served = hold_off_requests;
                stall_left      = HOLD_OFF_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Readings under the calibration left by reset: the ends of both ranges, a
    // temperature right at the offset, and whole degrees that saturate both ways.
    task automatic test_reset_values();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_reading(16'd0, 16'd0);
        send_reading(16'hFFFF, 16'hFFFF);
        send_reading(TEMP_CAL_ONE_RST, 16'd0);
        send_reading(TEMP_CAL_ONE_RST, 16'hFFFF);
        send_reading(16'd0, 16'hFFFF);
        send_reading(16'hFFFF, 16'd0);
    endtask

    // Every register at both of its extremes. The first set drives temp_centi into
    // positive saturation and humidity past full scale, the second and third into
    // negative saturation, with the humidity offset and gains at their other ends.
    task automatic test_calibration_extremes();
        cal_set_t sets [3];
        sets[0] = '{16'h0000, 16'h7FFF, 16'h0000, 16'hFFFF,
                    16'h007F, 16'h007F, 16'h00FF, 16'h007F};
        sets[1] = '{16'h0000, 16'h8000, 16'hFFFF, 16'hFFFF,
                    16'h0080, 16'h0080, 16'h0000, 16'h0080};
        sets[2] = '{16'hFFFF, 16'h7FFF, 16'h0000, 16'h0000,
                    16'h0080, 16'h007F, 16'h0000, 16'h0080};
        foreach (sets[s])
        begin
            wait_drained();
            load_calibration(sets[s]);
            send_reading(16'd0, 16'd0);
            send_reading(16'd0, 16'hFFFF);
            send_reading(16'hFFFF, 16'd0);
            send_reading(16'hFFFF, 16'hFFFF);
        end
    endtask

    // The bulk of the run: for each idling pattern, two fresh calibrations, one with
    // a plausible humidity offset and one fully random.
    task automatic test_random_readings();
        int send_pcts [4] = '{0, 53, 0, 21};
        int recv_pcts [4] = '{0, 0, 53, 21};
        for (int mode = 0; mode < 4; mode++)
        begin
            for (int k = 0; k < 2; k++)
            begin
                wait_drained();
                load_calibration(random_calibration(k == 0));
                send_idle_pct  = send_pcts[mode];
                recv_stall_pct = recv_pcts[mode];
                repeat (ITEMS_PER_PHASE)
                    send_random_reading();
            end
        end
    endtask

    // The receiver holds off for a long stretch while items keep coming, so the
    // pipeline fills and must stall its input without losing or repeating anything.
    task automatic test_output_backpressure();
        wait_drained();
        load_calibration(random_calibration(1'b1));
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_requests++;
        repeat (BACKLOG_ITEMS)
            send_random_reading();
    endtask

    // The sender stops in mid-stream until every result has come back, then resumes.
    task automatic test_sender_pause();
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        repeat (PAUSE_ITEMS)
            send_random_reading();
        wait_drained();
        repeat (PAUSE_ITEMS)
            send_random_reading();
    endtask

    initial
    begin : test_sequence
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_calibration_extremes();
        test_random_readings();
        test_output_backpressure();
        test_sender_pause();

        // Let the pipeline run dry, then give any stray result time to show up.
        wait_drained();
        repeat (2 * NUM_STAGES)
            @(posedge clk);
        if (mismatch_count == 0 && expected_readings.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, even with every stall at its worst.
    initial
    begin : watchdog
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule

// ----- sim.f -----
design/thc_pkg.sv
design/temp_humidity_compensation.sv
design/thc_checker.sv
tb/tb_temp_humidity_compensation.sv
